### rtl/core/assert_macros.svh
// Assertion macros shared by the merge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk_i edge, masked while rst_ni is low.
`define KWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising clk_i edge, reset included.
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/kwm_pkg.sv
// Shared constants, types and helper functions of the k-way merge block.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int KeyW   = 64;
  localparam int OffW   = 32;
  localparam int TimeW  = 32;
  localparam int RunW   = 3;
  localparam int MaskW  = 8;
  localparam int CfgW   = 4;
  localparam int HeadW  = KeyW + OffW + TimeW;
  localparam int InDataW  = HeadW;
  localparam int OutDataW = KeyW + OffW + MaskW;

  // A 3-bit run index can address no more than eight runs.
  localparam int RunLimit    = 8;
  localparam int MaxRunsDef  = 8;
  localparam logic [CfgW-1:0] CfgResetRuns = 4'd8;

  typedef struct packed {
    logic clear;
    logic sample;
    logic head_valid;
  } kwm_scan_ctrl_t;

  // Effective run count: zero acts as one, saturate at the storage depth.
  function automatic logic [CfgW-1:0] active_runs(logic [CfgW-1:0] v, int unsigned depth);
    logic [CfgW-1:0] n;
    n = v;
    if (v == '0) begin
      n = CfgW'(1);
    end else if (32'(v) > depth) begin
      n = CfgW'(depth);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/kwm_head_mem.sv
// Head entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kwm_head_mem #(
  parameter int Depth = kwm_pkg::MaxRunsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [kwm_pkg::HeadW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [kwm_pkg::HeadW-1:0] rdata_o
);

  logic [kwm_pkg::HeadW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/kwm_scan.sv
// Running minimum over the head entries: smallest key, newest time, duplicate mask.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kwm_scan #(
  parameter int Depth = kwm_pkg::MaxRunsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire kwm_pkg::kwm_scan_ctrl_t   ctrl_i,
  input  wire logic [AddrW-1:0]          idx_i,
  input  wire logic [kwm_pkg::HeadW-1:0] head_i,
  output logic                           found_o,
  output logic      [kwm_pkg::KeyW-1:0]  best_key_o,
  output logic      [kwm_pkg::OffW-1:0]  best_off_o,
  output logic      [AddrW-1:0]          win_o,
  output logic      [Depth-1:0]          mask_o
);

  logic [kwm_pkg::KeyW-1:0]  key;
  logic [kwm_pkg::OffW-1:0]  off;
  logic [kwm_pkg::TimeW-1:0] tim;

  logic                      found_q, found_d;
  logic [Depth-1:0]          mask_q, mask_d;
  logic [kwm_pkg::KeyW-1:0]  key_q, key_d;
  logic [kwm_pkg::OffW-1:0]  off_q, off_d;
  logic [kwm_pkg::TimeW-1:0] time_q, time_d;
  logic [AddrW-1:0]          win_q, win_d;

  assign key = head_i[kwm_pkg::KeyW-1:0];
  assign off = head_i[kwm_pkg::KeyW +: kwm_pkg::OffW];
  assign tim = head_i[kwm_pkg::KeyW + kwm_pkg::OffW +: kwm_pkg::TimeW];

  always_comb begin
    found_d = found_q;
    mask_d  = mask_q;
    key_d   = key_q;
    off_d   = off_q;
    time_d  = time_q;
    win_d   = win_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
      mask_d  = '0;
    end else if (ctrl_i.sample && ctrl_i.head_valid) begin
      if (!found_q || key < key_q) begin
        // New minimum: restart the duplicate set.
        found_d = 1'b1;
        key_d   = key;
        off_d   = off;
        time_d  = tim;
        win_d   = idx_i;
        mask_d  = Depth'(1) << idx_i;
      end else if (key == key_q) begin
        mask_d = mask_q | (Depth'(1) << idx_i);
        // Strictly newer wins; equal labels keep the lower run.
        if (tim > time_q) begin
          off_d  = off;
          time_d = tim;
          win_d  = idx_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      mask_q  <= '0;
    end else begin
      found_q <= found_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    off_q  <= off_d;
    time_q <= time_d;
    win_q  <= win_d;
  end

  assign found_o    = found_q;
  assign best_key_o = key_q;
  assign best_off_o = off_q;
  assign win_o      = win_q;
  assign mask_o     = mask_q;

  `KWM_ASSERT(a_mask_iff_found, found_q == (mask_q != '0), "mask out of step")
  `KWM_ASSERT(a_winner_in_mask, found_q |-> mask_q[win_q], "winner missing from refill mask")

endmodule

`default_nettype wire

### rtl/core/kway_merge_newest_wins_top.sv
// Top level of the k-way merge with newest-wins duplicate removal.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage
//   s_axis: one request per run head. tuser names the run, tlast marks the run
//   exhausted (tdata then ignored). A request is taken only for a run in use
//   whose bit is set in the pending refill set; other requests are swallowed.
//   m_axis: one result per selection. tlast high marks the end of the merge,
//   with tdata and tuser zero; the block then rearms for a new merge.
//   cfg: write runs_in_use; the write restarts the merge (all runs in use pending).
// Timing
//   A request that leaves refills pending only updates its head and pending bit.
//   The request that completes the refill set starts a scan of the head store:
//   one entry read per cycle from the single read port for the n runs in use, then
//   the drain and finish states put the result in the output register.
// Reset
//   Runs in use return to eight, no head is valid, every run awaits a refill.
// Stall
//   The output register holds a result until m_axis_tready_i; the block keeps
//   taking refill requests meanwhile and only waits if a new result is ready
//   while the old one is still held.

module kway_merge_newest_wins_top #(
  parameter int MAX_RUNS = kwm_pkg::MaxRunsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // entry_key [63:0], entry_offset [95:64], run_time [127:96]
  input  wire logic [kwm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // run_index [2:0]
  input  wire logic [kwm_pkg::RunW-1:0]      s_axis_tuser_i,
  // run_done
  input  wire logic                          s_axis_tlast_i,

  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // out_key [63:0], out_offset [95:64], refill_mask [103:96]
  output logic      [kwm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // out_run [2:0]
  output logic      [kwm_pkg::RunW-1:0]      m_axis_tuser_o,
  // merge_done
  output logic                               m_axis_tlast_o,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kwm_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int Depth = (MAX_RUNS < kwm_pkg::RunLimit) ? MAX_RUNS : kwm_pkg::RunLimit;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e                      state_q, state_d;
  logic [kwm_pkg::CfgW-1:0]    cfg_q, cfg_d;
  logic [Depth-1:0]            valid_q, valid_d;
  logic [Depth-1:0]            await_q, await_d;
  logic [AddrW-1:0]            cnt_q, cnt_d;
  logic                        rd_pend_q, rd_pend_d;
  logic [AddrW-1:0]            rd_idx_q, rd_idx_d;
  logic                        out_valid_q, out_valid_d;
  logic [kwm_pkg::KeyW-1:0]    out_key_q, out_key_d;
  logic [kwm_pkg::OffW-1:0]    out_off_q, out_off_d;
  logic [kwm_pkg::MaskW-1:0]   out_mask_q, out_mask_d;
  logic [kwm_pkg::RunW-1:0]    out_run_q, out_run_d;
  logic                        out_last_q, out_last_d;

  logic [kwm_pkg::CfgW-1:0]    n_eff, n_new;
  logic [Depth-1:0]            run_mask, run_mask_new;
  logic                        in_acc, cfg_acc, hit, out_free;
  logic [AddrW-1:0]            in_idx;
  logic                        mem_we;
  logic                        out_zero;

  kwm_pkg::kwm_scan_ctrl_t     scan_ctrl;
  logic                        found;
  logic [kwm_pkg::KeyW-1:0]    best_key;
  logic [kwm_pkg::OffW-1:0]    best_off;
  logic [AddrW-1:0]            win;
  logic [Depth-1:0]            dup_mask;
  logic [kwm_pkg::HeadW-1:0]   rd_head;

  assign n_eff = kwm_pkg::active_runs(cfg_q, Depth);
  assign n_new = kwm_pkg::active_runs(cfg_data_i, Depth);

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      run_mask[j]     = kwm_pkg::CfgW'(j) < n_eff;
      run_mask_new[j] = kwm_pkg::CfgW'(j) < n_new;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign in_idx   = s_axis_tuser_i[AddrW-1:0];
  // Take the request only for a run in use that still awaits its refill.
  assign hit      = in_acc && ({1'b0, s_axis_tuser_i} < n_eff) && await_q[in_idx];
  assign mem_we   = hit && !s_axis_tlast_i && !cfg_acc;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign scan_ctrl.clear      = hit && (state_d == S_SCAN);
  assign scan_ctrl.sample     = rd_pend_q;
  assign scan_ctrl.head_valid = valid_q[rd_idx_q];

  kwm_head_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_head_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_idx),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (cnt_q),
    .rdata_o (rd_head)
  );

  kwm_scan #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .idx_i      (rd_idx_q),
    .head_i     (rd_head),
    .found_o    (found),
    .best_key_o (best_key),
    .best_off_o (best_off),
    .win_o      (win),
    .mask_o     (dup_mask)
  );

  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    valid_d     = valid_q;
    await_d     = await_q;
    cnt_d       = cnt_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_key_d   = out_key_q;
    out_off_d   = out_off_q;
    out_mask_d  = out_mask_q;
    out_run_d   = out_run_q;
    out_last_d  = out_last_q;

    if (cfg_acc) begin
      // Restart the merge under the new run count.
      cfg_d   = cfg_data_i;
      valid_d = '0;
      await_d = run_mask_new;
      state_d = S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (hit) begin
            valid_d[in_idx] = !s_axis_tlast_i;
            await_d[in_idx] = 1'b0;
            if ((await_q & ~(Depth'(1) << in_idx)) == '0) begin
              state_d = S_SCAN;
              cnt_d   = '0;
            end
          end
        end
        S_SCAN: begin
          rd_pend_d = 1'b1;
          rd_idx_d  = cnt_q;
          if (cnt_q == AddrW'(n_eff - kwm_pkg::CfgW'(1))) begin
            state_d = S_DRAIN;
          end else begin
            cnt_d = cnt_q + AddrW'(1);
          end
        end
        S_DRAIN: begin
          // Last read data is folded into the running minimum this cycle.
          state_d = S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_d = 1'b1;
            if (found) begin
              out_key_d  = best_key;
              out_off_d  = best_off;
              out_mask_d = kwm_pkg::MaskW'(dup_mask);
              out_run_d  = kwm_pkg::RunW'(win);
              out_last_d = 1'b0;
              await_d    = dup_mask;
            end else begin
              // Every run exhausted: emit done and rearm.
              out_key_d  = '0;
              out_off_d  = '0;
              out_mask_d = '0;
              out_run_d  = '0;
              out_last_d = 1'b1;
              valid_d    = '0;
              await_d    = run_mask;
            end
            state_d = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= kwm_pkg::CfgResetRuns;
      valid_q     <= '0;
      await_q     <= '1;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      valid_q     <= valid_d;
      await_q     <= await_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    out_off_q  <= out_off_d;
    out_mask_q <= out_mask_d;
    out_run_q  <= out_run_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_mask_q, out_off_q, out_key_q};
  assign m_axis_tuser_o  = out_run_q;
  assign m_axis_tlast_o  = out_last_q;

  assign out_zero = ({m_axis_tdata_o, m_axis_tuser_o} == '0);

  `KWM_ASSERT(a_scan_no_pending, state_q != S_IDLE |-> await_q == '0, "refill pending in scan")
  `KWM_ASSERT(a_pending_in_use, (await_q & ~run_mask) == '0, "pending run not in use")
  `KWM_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q) == S_FINISH, "no finish")
  `KWM_ASSERT(a_done_zero, out_valid_q && out_last_q |-> out_zero, "nonzero done result")

endmodule

`default_nettype wire
